// ===== rtl/nearest_waypoint_set_search_assert.svh =====
// ----------------------------------------------------------------------------
// Nearest waypoint set search assertion macros
// Property wrappers sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef NEAREST_WAYPOINT_SET_SEARCH_ASSERT_SVH
`define NEAREST_WAYPOINT_SET_SEARCH_ASSERT_SVH

// same-cycle implication
`define NWS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/nws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest waypoint set search package
// Field widths, codes and shared types of the waypoint search block.
// ----------------------------------------------------------------------------
package nws_pkg;

	localparam int INDEX_W    = 10;
	localparam int STATUS_W   = 2;
	localparam int THR_W      = 24;
	localparam int LEN_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam int M_TDATA_W  = 16;

	localparam logic [THR_W-1:0] THR_RESET = 24'd256;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATH_LEN  = 1'd1;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_TRUNC = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} nws_sqrt_stat_t;

endpackage

// ===== rtl/nws_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest waypoint set search RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nws_ram #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 48,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/nws_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest waypoint set search square root unit
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module nws_isqrt
	import nws_pkg::*;
#(
	parameter int RAD_W = 52,
	localparam int ROOT_W = RAD_W / 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic [ROOT_W-1:0] root,
	output nws_sqrt_stat_t    stat
);

	logic [RAD_W-1:0] n_q;
	logic [RAD_W-1:0] root_q;
	logic [RAD_W-1:0] bit_q;
	logic             busy_q;
	logic             done_q;
	logic [RAD_W-1:0] trial;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			root_q <= '0;
			bit_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && bit_q[0];
			if (start) begin
				n_q    <= radicand;
				root_q <= '0;
				bit_q  <= RAD_W'(1) << (RAD_W - 2);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (n_q >= trial) begin
					n_q    <= n_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign root = root_q[ROOT_W-1:0];
	assign stat = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/nearest_waypoint_set_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest waypoint set search
// Waypoint table with a query scan that lists the closest set of entries.
//
// channel | dir | handshake          | content
// s_*     | in  | s_tvalid, s_tready | tuser func; tdata entry index, pos_x, pos_y
// m_*     | out | m_tvalid, m_tready | tuser status; tdata match_index; tlast last
// cfg_*   | in  | cfg_valid, cfg_ready | cfg_index register, cfg_data value
//
// A query scans path_length - 1 entries, each distance going through the iterative
// square root unit, then reads out each result through ST_OUT_RD and ST_OUT_LD.
// A short path gives one result.
// Reset clears control state; the waypoint and match memories are not cleared.
// A stalled result holds in the output register and holds the read-out;
// requests wait until the query ends.
// ----------------------------------------------------------------------------
`include "nearest_waypoint_set_search_assert.svh"

module nearest_waypoint_set_search
	import nws_pkg::*;
#(
	parameter int PATH_DEPTH  = 1024,
	parameter int MAX_MATCHES = 64,
	parameter int COORD_WIDTH = 24,
	localparam int S_TDATA_W = ((INDEX_W + 2 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // entry index, pos_x, pos_y, zero fill
	input  logic                  s_tuser,   // func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,   // match_index, zero fill
	output logic [STATUS_W-1:0]   m_tuser,   // status
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW     = COORD_WIDTH;
	localparam int AW     = $clog2(PATH_DEPTH);
	localparam int LW     = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
	localparam int MC_W   = $clog2(MAX_MATCHES + 1);
	localparam int SUM_W  = 2 * CW + 1;
	localparam int RAD_W  = (2 * CW + 2 > 64) ? 64 : 2 * CW + 2;
	localparam int DIST_W = RAD_W / 2;
	localparam int CMP_W  = ((DIST_W > THR_W) ? DIST_W : THR_W) + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHORT,
		ST_RD,
		ST_LAT,
		ST_SQX,
		ST_SQY,
		ST_SUM,
		ST_ROOT,
		ST_UPD,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	state_t              state_q;
	logic [THR_W-1:0]    thr_q;
	logic [LEN_W-1:0]    plen_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    i_q;
	logic [CW-1:0]       qx_q;
	logic [CW-1:0]       qy_q;
	logic [CW-1:0]       dx_q;
	logic [CW-1:0]       dy_q;
	logic [2*CW-1:0]     sx_q;
	logic [2*CW-1:0]     sy_q;
	logic [DIST_W-1:0]   ref_q;
	logic [MC_W-1:0]     cnt_q;
	logic                trunc_q;
	logic [MC_W-1:0]     k_q;
	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0] m_tuser_q;
	logic                m_tlast_q;

	logic                s_acc;
	logic [INDEX_W-1:0]  in_idx;
	logic [CW-1:0]       in_x;
	logic [CW-1:0]       in_y;
	logic [LEN_W-1:0]    len_clamp;
	logic                wp_we;
	logic [2*CW-1:0]     wp_rdata;
	logic [CW-1:0]       wx;
	logic [CW-1:0]       wy;
	logic [CW:0]         dxw;
	logic [CW:0]         dyw;
	logic [CW:0]         dxn;
	logic [CW:0]         dyn;
	logic [CW-1:0]       dx_abs;
	logic [CW-1:0]       dy_abs;
	logic [CW-1:0]       mul_a;
	logic [2*CW-1:0]     mul_p;
	logic [SUM_W-1:0]    sum_w;
	logic [RAD_W-1:0]    radicand;
	logic [DIST_W-1:0]   root_dist;
	nws_sqrt_stat_t      sq_stat;
	logic [DIST_W-1:0]   diff;
	logic                restart;
	logic                near;
	logic                room;
	logic                ml_we;
	logic [LW-1:0]       ml_waddr;
	logic [INDEX_W-1:0]  ml_rdata;
	logic [LEN_W-1:0]    i_nx;
	logic                scan_end;
	logic                out_free;
	logic                k_last;
	logic                m_load;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign in_idx = s_tdata[INDEX_W-1:0];
	assign in_x   = s_tdata[INDEX_W +: CW];
	assign in_y   = s_tdata[INDEX_W + CW +: CW];

	assign len_clamp = (32'(plen_q) > PATH_DEPTH) ? LEN_W'(PATH_DEPTH) : plen_q;

	assign wp_we = s_acc && (s_tuser == FUNC_LOAD) && (32'(in_idx) < PATH_DEPTH);

	nws_ram #(
		.DEPTH  (PATH_DEPTH),
		.DATA_W (2 * CW)
	) u_wp_ram (
		.clk   (clk),
		.we    (wp_we),
		.waddr (AW'(in_idx)),
		.wdata ({in_y, in_x}),
		.raddr (AW'(i_q)),
		.rdata (wp_rdata)
	);

	assign wx     = wp_rdata[CW-1:0];
	assign wy     = wp_rdata[2*CW-1:CW];
	assign dxw    = {wx[CW-1], wx} - {qx_q[CW-1], qx_q};
	assign dyw    = {wy[CW-1], wy} - {qy_q[CW-1], qy_q};
	assign dxn    = '0 - dxw;
	assign dyn    = '0 - dyw;
	assign dx_abs = dxw[CW] ? dxn[CW-1:0] : dxw[CW-1:0];
	assign dy_abs = dyw[CW] ? dyn[CW-1:0] : dyw[CW-1:0];

	assign mul_a = (state_q == ST_SQX) ? dx_q : dy_q;
	assign mul_p = (2 * CW)'(mul_a) * (2 * CW)'(mul_a);
	assign sum_w = SUM_W'(sx_q) + SUM_W'(sy_q);

	generate
		if (SUM_W > RAD_W) begin : g_sat
			assign radicand = sum_w[SUM_W-1] ? '1 : sum_w[RAD_W-1:0];
		end else begin : g_nosat
			assign radicand = RAD_W'(sum_w);
		end
	endgenerate

	nws_isqrt #(
		.RAD_W (RAD_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_SUM),
		.radicand (radicand),
		.root     (root_dist),
		.stat     (sq_stat)
	);

	assign restart = (i_q == LEN_W'(1)) ||
		(CMP_W'(ref_q) > CMP_W'(root_dist) + CMP_W'(thr_q));
	assign diff    = (ref_q > root_dist) ? ref_q - root_dist : root_dist - ref_q;
	assign near    = CMP_W'(diff) < CMP_W'(thr_q);
	assign room    = 32'(cnt_q) < MAX_MATCHES;

	assign ml_we    = (state_q == ST_UPD) && (restart || (near && room));
	assign ml_waddr = restart ? '0 : LW'(cnt_q);

	nws_ram #(
		.DEPTH  (MAX_MATCHES),
		.DATA_W (INDEX_W)
	) u_match_ram (
		.clk   (clk),
		.we    (ml_we),
		.waddr (ml_waddr),
		.wdata (INDEX_W'(i_q)),
		.raddr (LW'(k_q)),
		.rdata (ml_rdata)
	);

	assign i_nx     = i_q + LEN_W'(1);
	assign scan_end = (i_nx >= len_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign k_last   = ((k_q + MC_W'(1)) == cnt_q);
	assign m_load   = ((state_q == ST_SHORT) || (state_q == ST_OUT_LD)) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			plen_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q  <= cfg_data[THR_W-1:0];
				REG_PATH_LEN:  plen_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			len_q      <= '0;
			i_q        <= '0;
			qx_q       <= '0;
			qy_q       <= '0;
			dx_q       <= '0;
			dy_q       <= '0;
			sx_q       <= '0;
			sy_q       <= '0;
			ref_q      <= '0;
			cnt_q      <= '0;
			trunc_q    <= 1'b0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= STATUS_OK;
			m_tlast_q  <= 1'b0;
		end else begin
			if (m_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc && (s_tuser == FUNC_QUERY)) begin
						qx_q  <= in_x;
						qy_q  <= in_y;
						len_q <= len_clamp;
						i_q   <= LEN_W'(1);
						state_q <= (len_clamp < LEN_W'(2)) ? ST_SHORT : ST_RD;
					end
				end
				ST_SHORT: begin
					if (out_free) begin
						m_tdata_q  <= '0;
						m_tuser_q  <= STATUS_SHORT;
						m_tlast_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_LAT;
				end
				ST_LAT: begin
					dx_q    <= dx_abs;
					dy_q    <= dy_abs;
					state_q <= ST_SQX;
				end
				ST_SQX: begin
					sx_q    <= mul_p;
					state_q <= ST_SQY;
				end
				ST_SQY: begin
					sy_q    <= mul_p;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (sq_stat.done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (restart) begin
						ref_q   <= root_dist;
						cnt_q   <= MC_W'(1);
						trunc_q <= 1'b0;
					end else if (near) begin
						if (room) begin
							cnt_q <= cnt_q + MC_W'(1);
						end else begin
							trunc_q <= 1'b1;
						end
					end
					i_q <= i_nx;
					if (scan_end) begin
						k_q     <= '0;
						state_q <= ST_OUT_RD;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					if (out_free) begin
						m_tdata_q  <= M_TDATA_W'(ml_rdata);
						m_tuser_q  <= trunc_q ? STATUS_TRUNC : STATUS_OK;
						m_tlast_q  <= k_last;
						k_q        <= k_q + MC_W'(1);
						state_q    <= k_last ? ST_IDLE : ST_OUT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`NWS_ASSERT_SAME(a_root_in_scan, sq_stat.busy || sq_stat.done, state_q == ST_ROOT, "square root unit active outside scan")
	`NWS_ASSERT_NEXT(a_short_path, s_acc && (s_tuser == FUNC_QUERY) && (len_clamp < LEN_W'(2)), state_q == ST_SHORT, "short path query not flagged")
	`NWS_ASSERT_SAME(a_emit_count, state_q == ST_OUT_LD, (cnt_q != '0) && (k_q < cnt_q) && (32'(cnt_q) <= MAX_MATCHES), "match list read out of range")

endmodule
